>>> hdl/brb_pkg.sv
package brb_pkg;

    // Store geometry and block limits.
    localparam int DEPTH     = 256;
    localparam int MAX_BLOCK = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CAP_W     = PTR_W + 1;
    localparam int BLK_W     = $clog2(MAX_BLOCK + 1);
    localparam int DATA_W    = 8;

    // Request codes carried in the input tuser.
    typedef enum logic [2:0] {
        REQ_WRITE  = 3'd0,
        REQ_PEEK   = 3'd1,
        REQ_GET    = 3'd2,
        REQ_GETBLK = 3'd3,
        REQ_REWIND = 3'd4,
        REQ_LEVEL  = 3'd5,
        REQ_CLEAR  = 3'd6,
        REQ_NOP    = 3'd7
    } t_req;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DROP  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_BRD,
        S_BOUT,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // ready for an input transfer
        logic exec;   // carry out the captured request
        logic walk;   // advance the read pointer by one byte of a block get
        logic brd;    // read one byte of a block get
        logic bout;   // load one block byte into the output register
        logic emit;   // load the single result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_fire;   // input transfer this cycle
        t_req req;       // captured request code
        logic blk_ok;    // block get passes its checks
        logic cnt_last;  // block byte counter is at its final byte
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

>>> hdl/brb_ctrl.sv
module brb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  brb_pkg::t_sts i_sts,
    output brb_pkg::t_cmd o_cmd
);

    brb_pkg::t_state r_state;
    brb_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            brb_pkg::S_IDLE: begin
                if (i_sts.in_fire) n_state = brb_pkg::S_EXEC;
            end
            brb_pkg::S_EXEC: begin
                if (i_sts.req == brb_pkg::REQ_GETBLK && i_sts.blk_ok) begin
                    n_state = brb_pkg::S_WALK;
                end else begin
                    n_state = brb_pkg::S_EMIT;
                end
            end
            brb_pkg::S_WALK: begin
                if (i_sts.cnt_last) n_state = brb_pkg::S_BRD;
            end
            brb_pkg::S_BRD: begin
                n_state = brb_pkg::S_BOUT;
            end
            brb_pkg::S_BOUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.cnt_last ? brb_pkg::S_IDLE : brb_pkg::S_BRD;
                end
            end
            brb_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = brb_pkg::S_IDLE;
            end
            default: begin
                n_state = brb_pkg::S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            brb_pkg::S_IDLE: o_cmd.take = 1'b1;
            brb_pkg::S_EXEC: o_cmd.exec = 1'b1;
            brb_pkg::S_WALK: o_cmd.walk = 1'b1;
            brb_pkg::S_BRD:  o_cmd.brd  = 1'b1;
            brb_pkg::S_BOUT: o_cmd.bout = i_sts.out_free;
            brb_pkg::S_EMIT: o_cmd.emit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> hdl/brb_datapath.sv
module brb_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  brb_pkg::t_cmd               i_cmd,
    output brb_pkg::t_sts               o_sts,
    input  logic                        i_cfg_we,
    input  logic [brb_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic [23:0]                 i_in_data,
    input  logic [3:0]                  i_in_user,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [23:0]                 o_out_data,
    output logic                        o_out_last
);

    localparam int PW = brb_pkg::PTR_W;
    localparam int CW = brb_pkg::CAP_W;
    localparam int BW = brb_pkg::BLK_W;
    localparam int DW = brb_pkg::DATA_W;

    // Captured request.
    brb_pkg::t_req    r_req;
    logic [DW-1:0]    r_din;
    logic [CW-1:0]    r_cnt;
    logic             r_first;

    // Buffer state.
    logic [CW-1:0]    r_cap;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_wp, n_wp;
    logic             r_full, n_full;
    logic             r_acc, n_acc;
    logic [CW-1:0]    r_rem, n_rem;
    logic [BW-1:0]    r_left, n_left;
    logic [PW-1:0]    r_addr, n_addr;
    brb_pkg::t_status r_status, n_status;
    logic             r_use_rd, n_use_rd;

    // Byte store with per-entry valid bits; an invalid entry reads as zero.
    logic [DW-1:0]    r_mem [brb_pkg::DEPTH];
    logic [brb_pkg::DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rdata;
    logic             r_rvld;
    logic             mem_we, mem_re, wipe;
    logic [PW-1:0]    mem_wa, mem_ra;

    // Output register.
    logic             r_ovalid;
    logic [DW-1:0]    r_odata;
    brb_pkg::t_status r_ostat;
    logic [CW-1:0]    r_olvl;
    logic             r_olast;

    logic [CW-1:0]    w_lvl;
    logic [DW-1:0]    w_rd;
    logic             w_fire, w_out_free, w_blk_ok;

    // Step a pointer forward, wrapping at the capacity.
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p,
                                          input logic [CW-1:0] c);
        logic [CW-1:0] n;
        n = {1'b0, p} + CW'(1);
        return (n >= c) ? '0 : n[PW-1:0];
    endfunction

    // Fill level from the pointers, clamped to 0..capacity.
    function automatic logic [CW-1:0] fill(input logic [PW-1:0] rp,
                                           input logic [PW-1:0] wp,
                                           input logic          full,
                                           input logic [CW-1:0] c);
        logic signed [CW+1:0] d;
        logic [CW-1:0]        r;
        d = $signed({2'b00, c}) - $signed({3'b000, rp}) + $signed({3'b000, wp});
        if (rp == wp) begin
            r = full ? c : '0;
        end else if (wp > rp) begin
            r = {1'b0, wp} - {1'b0, rp};
            if (r > c) r = c;
        end else if (d < 0) begin
            r = '0;
        end else if (d > $signed({2'b00, c})) begin
            r = c;
        end else begin
            r = d[CW-1:0];
        end
        return r;
    endfunction

    assign w_fire     = i_in_valid && i_cmd.take;
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_lvl      = fill(r_rp, r_wp, r_full, r_cap);
    assign w_rd       = r_rvld ? r_rdata : '0;
    assign w_blk_ok   = (r_cnt != '0) && (r_cnt <= CW'(brb_pkg::MAX_BLOCK))
                        && (r_cnt <= w_lvl);

    assign o_sts.in_fire  = w_fire;
    assign o_sts.req      = r_req;
    assign o_sts.blk_ok   = w_blk_ok;
    assign o_sts.cnt_last = (r_left == BW'(1));
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {5'b0, r_olvl, r_ostat, r_odata};
    assign o_out_last  = r_olast;

    // Request execution, block walk and block read addressing.
    always_comb begin
        logic          ok;
        logic          acc_mid;
        logic [CW-1:0] rem_mid;
        logic [PW-1:0] wp_nx;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_full   = r_full;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_left   = r_left;
        n_addr   = r_addr;
        n_status = r_status;
        n_use_rd = r_use_rd;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        wipe     = 1'b0;
        mem_wa   = r_wp;
        mem_ra   = r_rp;
        ok       = 1'b0;
        acc_mid  = r_acc;
        rem_mid  = r_rem;
        wp_nx    = adv(r_wp, r_cap);

        if (i_cmd.exec) begin
            n_status = brb_pkg::ST_OK;
            n_use_rd = 1'b0;
            case (r_req)
                brb_pkg::REQ_WRITE: begin
                    // Space check happens on the first byte of a block.
                    if (r_first) begin
                        if (w_lvl == '0) ok = 1'b1;
                        else if (w_lvl >= r_cap) ok = 1'b0;
                        else ok = (r_cnt <= (r_cap - w_lvl));
                        acc_mid = ok;
                        rem_mid = ok ? r_cnt : '0;
                    end
                    if (!acc_mid || rem_mid == '0) begin
                        n_status = brb_pkg::ST_DROP;
                    end else begin
                        rem_mid = rem_mid - CW'(1);
                        if (r_full && r_rp == r_wp) begin
                            n_status = brb_pkg::ST_DROP;
                        end else begin
                            mem_we = 1'b1;
                            n_wp   = wp_nx;
                            if (wp_nx == r_rp) n_full = 1'b1;
                        end
                    end
                    n_rem = rem_mid;
                    n_acc = (rem_mid == '0) ? 1'b0 : acc_mid;
                end
                brb_pkg::REQ_PEEK, brb_pkg::REQ_GET: begin
                    if (w_lvl == '0) begin
                        n_status = brb_pkg::ST_EMPTY;
                    end else begin
                        mem_re   = 1'b1;
                        n_use_rd = 1'b1;
                        if (r_req == brb_pkg::REQ_GET) begin
                            n_rp   = adv(r_rp, r_cap);
                            n_full = 1'b0;
                        end
                    end
                end
                brb_pkg::REQ_GETBLK: begin
                    if (w_blk_ok) begin
                        n_addr = r_rp;
                        n_left = r_cnt[BW-1:0];
                    end else begin
                        n_status = brb_pkg::ST_EMPTY;
                    end
                end
                brb_pkg::REQ_REWIND: begin
                    if (r_cnt != '0 && r_cnt < r_cap) begin
                        if ({1'b0, r_rp} >= r_cnt) begin
                            n_rp = r_rp - r_cnt[PW-1:0];
                        end else begin
                            n_rp = PW'(r_cap - r_cnt + {1'b0, r_rp});
                        end
                        n_full = (n_rp == r_wp);
                    end
                end
                brb_pkg::REQ_CLEAR: begin
                    wipe   = 1'b1;
                    n_rp   = '0;
                    n_wp   = '0;
                    n_full = 1'b0;
                    n_acc  = 1'b0;
                    n_rem  = '0;
                end
                default: begin
                end
            endcase
        end

        // First pass of a block get: move the read pointer to its final place.
        if (i_cmd.walk) begin
            n_rp = adv(r_rp, r_cap);
            if (r_left == BW'(1)) begin
                n_left = r_cnt[BW-1:0];
                n_full = 1'b0;
            end else begin
                n_left = r_left - BW'(1);
            end
        end

        // Second pass: read the bytes from the saved start address.
        if (i_cmd.brd) begin
            mem_re = 1'b1;
            mem_ra = r_addr;
            n_addr = adv(r_addr, r_cap);
        end

        if (i_cmd.bout) begin
            n_left = r_left - BW'(1);
        end
    end

    // Control and pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CW'(brb_pkg::DEPTH);
            r_rp     <= '0;
            r_wp     <= '0;
            r_full   <= 1'b0;
            r_acc    <= 1'b0;
            r_rem    <= '0;
            r_left   <= '0;
            r_status <= brb_pkg::ST_OK;
            r_use_rd <= 1'b0;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_wdata == '0) r_cap <= CW'(1);
                else if (i_cfg_wdata > CW'(brb_pkg::DEPTH)) r_cap <= CW'(brb_pkg::DEPTH);
                else r_cap <= i_cfg_wdata;
            end
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_full   <= n_full;
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_left   <= n_left;
            r_status <= n_status;
            r_use_rd <= n_use_rd;
            if (wipe) begin
                r_vld <= '0;
            end else if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
        end
    end

    // Payload registers: captured request and block read address.
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (w_fire) begin
            r_req   <= brb_pkg::t_req'(i_in_user[2:0]);
            r_first <= i_in_user[3];
            r_din   <= i_in_data[DW-1:0];
            r_cnt   <= i_in_data[DW+CW-1:DW];
        end
    end

    // Byte store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= r_din;
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
            r_rvld  <= r_vld[mem_ra] && !(mem_we && wipe);
        end
    end

    // Output register; a new result loads as the previous one transfers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.bout) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= r_use_rd ? w_rd : '0;
            r_ostat <= r_status;
            r_olvl  <= w_lvl;
            r_olast <= 1'b1;
        end else if (i_cmd.bout) begin
            r_odata <= w_rd;
            r_ostat <= brb_pkg::ST_OK;
            r_olvl  <= w_lvl;
            r_olast <= (r_left == BW'(1));
        end
    end

endmodule

>>> hdl/byte_ring_buffer_rewind.sv
// Byte ring buffer with block writes, block gets and read pointer rewind.
// A request that gives one result passes through capture, execute and output load;
// the next request is taken only once that result is in the output register.
// A block get first walks the read pointer through the whole block in one pass,
// then each byte takes a store read and an output load on the single read port.
// Reset (synchronous, active low) empties the buffer, zeroes the store and sets capacity to 256.
module byte_ring_buffer_rewind (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: capacity register
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_in, [16:8] count, [23:17] zero
    input  logic [3:0]  s_axis_tuser,   // [2:0] req_type, [3] block_first
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_out, [9:8] status, [18:10] fill_level
    output logic        m_axis_tlast    // last result of the request
);

    brb_pkg::t_cmd cmd;
    brb_pkg::t_sts sts;

    assign s_axis_tready = cmd.take;

    // Sequencing of each request.
    brb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Pointers, byte store and result register.
    brb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // One request as it travels on the input stream.
    typedef struct packed {
        brb_pkg::t_req req;
        logic [7:0]    din;
        logic [8:0]    cnt;
        logic          first;
    } t_ring_req;

    // One result as it travels on the output stream.
    typedef struct packed {
        logic [7:0]       data;
        brb_pkg::t_status st;
        logic [8:0]       lvl;
        logic             last;
    } t_ring_result;

    // A directed row: the request, and a fixed expectation where one is given.
    typedef struct packed {
        t_ring_req    item;
        logic         fixed;
        t_ring_result res;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [8:0]  i_cfg_wdata   = 9'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;   // [7:0] data_in, [16:8] count, [23:17] zero
    logic [3:0]  s_axis_tuser  = 4'd0;    // [2:0] req_type, [3] block_first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [7:0] data_out, [9:8] status, [18:10] fill_level
    logic        m_axis_tlast;

    bit calm     = 1'b0;
    bit rx_quiet = 1'b0;
    int mismatch_cnt = 0;

    // Shadow copy of the buffer state.
    logic [7:0] shadow_mem [brb_pkg::DEPTH];
    int         shadow_rd;
    int         shadow_wr;
    bit         shadow_full;
    bit         shadow_blk_open;
    int         shadow_blk_left;
    int         shadow_cap;

    t_ring_result due_results [$];

    // Directed part: fixed expectations where they are obvious, the rest computed.
    t_dir_row dir_tab [0:25] = '{
        '{'{brb_pkg::REQ_PEEK, 8'h00, 9'd0, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_EMPTY, 9'd0, 1'b1}},
        '{'{brb_pkg::REQ_GET, 8'h00, 9'd0, 1'b1}, 1'b1,
          '{8'h00, brb_pkg::ST_EMPTY, 9'd0, 1'b1}},
        '{'{brb_pkg::REQ_GETBLK, 8'h00, 9'd1, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_EMPTY, 9'd0, 1'b1}},
        '{'{brb_pkg::REQ_LEVEL, 8'hFF, 9'd256, 1'b1}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd0, 1'b1}},
        '{'{brb_pkg::REQ_REWIND, 8'h00, 9'd0, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd0, 1'b1}},
        '{'{brb_pkg::REQ_WRITE, 8'h5A, 9'd0, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_DROP, 9'd0, 1'b1}},
        '{'{brb_pkg::REQ_WRITE, 8'h11, 9'd0, 1'b1}, 1'b1,
          '{8'h00, brb_pkg::ST_DROP, 9'd0, 1'b1}},
        '{'{brb_pkg::REQ_WRITE, 8'hFF, 9'd3, 1'b1}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd1, 1'b1}},
        '{'{brb_pkg::REQ_WRITE, 8'h00, 9'd0, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd2, 1'b1}},
        '{'{brb_pkg::REQ_WRITE, 8'hA5, 9'd256, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd3, 1'b1}},
        '{'{brb_pkg::REQ_WRITE, 8'h5A, 9'd0, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_DROP, 9'd3, 1'b1}},
        '{'{brb_pkg::REQ_PEEK, 8'h00, 9'd0, 1'b0}, 1'b1,
          '{8'hFF, brb_pkg::ST_OK, 9'd3, 1'b1}},
        '{'{brb_pkg::REQ_GETBLK, 8'h00, 9'd65, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_EMPTY, 9'd3, 1'b1}},
        '{'{brb_pkg::REQ_GETBLK, 8'h00, 9'd4, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_EMPTY, 9'd3, 1'b1}},
        '{'{brb_pkg::REQ_GETBLK, 8'h00, 9'd2, 1'b0}, 1'b0, '0},
        '{'{brb_pkg::REQ_REWIND, 8'h00, 9'd2, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd3, 1'b1}},
        '{'{brb_pkg::REQ_REWIND, 8'h00, 9'd256, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd3, 1'b1}},
        '{'{brb_pkg::REQ_GET, 8'h00, 9'd0, 1'b0}, 1'b1,
          '{8'hFF, brb_pkg::ST_OK, 9'd2, 1'b1}},
        '{'{brb_pkg::REQ_WRITE, 8'h33, 9'd255, 1'b1}, 1'b1,
          '{8'h00, brb_pkg::ST_DROP, 9'd2, 1'b1}},
        '{'{brb_pkg::REQ_WRITE, 8'h44, 9'd0, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_DROP, 9'd2, 1'b1}},
        '{'{brb_pkg::REQ_REWIND, 8'h00, 9'd254, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd256, 1'b1}},
        '{'{brb_pkg::REQ_WRITE, 8'h77, 9'd1, 1'b1}, 1'b1,
          '{8'h00, brb_pkg::ST_DROP, 9'd256, 1'b1}},
        '{'{brb_pkg::REQ_GET, 8'h00, 9'd0, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd255, 1'b1}},
        '{'{brb_pkg::REQ_GETBLK, 8'h00, 9'd64, 1'b0}, 1'b0, '0},
        '{'{brb_pkg::REQ_CLEAR, 8'h00, 9'd0, 1'b0}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd0, 1'b1}},
        '{'{brb_pkg::REQ_NOP, 8'hFF, 9'd511, 1'b1}, 1'b1,
          '{8'h00, brb_pkg::ST_OK, 9'd0, 1'b1}}
    };

    byte_ring_buffer_rewind dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Capacity in use: the register value clamped to 1..DEPTH.
    function automatic int ring_cap();
        if (shadow_cap == 0) return 1;
        if (shadow_cap > brb_pkg::DEPTH) return brb_pkg::DEPTH;
        return shadow_cap;
    endfunction

    // Pointer increment; a stale pointer at or past the capacity wraps to 0.
    function automatic int ring_next(input int p);
        return (p + 1 >= ring_cap()) ? 0 : p + 1;
    endfunction

    // Bytes held, clamped to 0..capacity.
    function automatic int ring_fill();
        int cap;
        int d;
        cap = ring_cap();
        if (shadow_rd == shadow_wr) return shadow_full ? cap : 0;
        if (shadow_wr > shadow_rd) d = shadow_wr - shadow_rd;
        else d = cap - shadow_rd + shadow_wr;
        if (d < 0) d = 0;
        if (d > cap) d = cap;
        return d;
    endfunction

    function automatic void ring_clear();
        foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
        shadow_rd       = 0;
        shadow_wr       = 0;
        shadow_full     = 1'b0;
        shadow_blk_open = 1'b0;
        shadow_blk_left = 0;
    endfunction

    // Carry one request through the shadow state and queue the results it gives.
    function automatic void ring_apply(input t_ring_req it);
        int           cap;
        int           lv;
        int           cnt;
        int           fin_lvl;
        bit           many;
        t_ring_result r;
        logic [7:0]   taken [brb_pkg::MAX_BLOCK];
        cap  = ring_cap();
        lv   = ring_fill();
        cnt  = it.cnt;
        many = 1'b0;
        r    = '{8'h00, brb_pkg::ST_OK, 9'd0, 1'b1};
        case (it.req)
            brb_pkg::REQ_WRITE: begin
                // The space check sits on the first byte of a block.
                if (it.first) begin
                    if (lv == 0) shadow_blk_open = 1'b1;
                    else if (lv >= cap) shadow_blk_open = 1'b0;
                    else shadow_blk_open = (cnt <= cap - lv);
                    shadow_blk_left = shadow_blk_open ? cnt : 0;
                end
                if (!shadow_blk_open || shadow_blk_left == 0) begin
                    r.st = brb_pkg::ST_DROP;
                end else begin
                    shadow_blk_left--;
                    if (shadow_full && shadow_rd == shadow_wr) begin
                        r.st = brb_pkg::ST_DROP;
                    end else begin
                        shadow_mem[shadow_wr] = it.din;
                        shadow_wr = ring_next(shadow_wr);
                        if (shadow_wr == shadow_rd) shadow_full = 1'b1;
                    end
                end
                if (shadow_blk_left == 0) shadow_blk_open = 1'b0;
            end
            brb_pkg::REQ_PEEK, brb_pkg::REQ_GET: begin
                if (lv == 0) begin
                    r.st = brb_pkg::ST_EMPTY;
                end else begin
                    r.data = shadow_mem[shadow_rd];
                    if (it.req == brb_pkg::REQ_GET) begin
                        shadow_rd   = ring_next(shadow_rd);
                        shadow_full = 1'b0;
                    end
                end
            end
            brb_pkg::REQ_GETBLK: begin
                if (cnt == 0 || cnt > brb_pkg::MAX_BLOCK || cnt > lv) begin
                    r.st = brb_pkg::ST_EMPTY;
                end else begin
                    // Every byte of a block get reports the level after the whole block.
                    for (int i = 0; i < cnt; i++) begin
                        taken[i]  = shadow_mem[shadow_rd];
                        shadow_rd = ring_next(shadow_rd);
                    end
                    shadow_full = 1'b0;
                    fin_lvl     = ring_fill();
                    for (int i = 0; i < cnt; i++) begin
                        due_results.push_back('{taken[i], brb_pkg::ST_OK, 9'(fin_lvl),
                                                i == cnt - 1});
                    end
                    many = 1'b1;
                end
            end
            brb_pkg::REQ_REWIND: begin
                if (cnt != 0 && cnt < cap) begin
                    if (shadow_rd >= cnt) shadow_rd = shadow_rd - cnt;
                    else shadow_rd = cap - (cnt - shadow_rd);
                    shadow_full = (shadow_rd == shadow_wr);
                end
            end
            brb_pkg::REQ_CLEAR: begin
                ring_clear();
            end
            default: begin
            end
        endcase
        if (!many) begin
            r.lvl = 9'(ring_fill());
            due_results.push_back(r);
        end
    endfunction

    function automatic void note_mismatch(input string why, input t_ring_result want,
                                          input t_ring_result got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t: %s: want data %02h status %0d level %0d last %0b", $realtime, why,
                     want.data, want.st, want.lvl, want.last);
            $display("%0t: %s: got  data %02h status %0d level %0d last %0b", $realtime, why,
                     got.data, got.st, got.lvl, got.last);
        end
    endfunction

    // Result checker: each transfer against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_ring_result got;
        t_ring_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data = m_axis_tdata[7:0];
            got.st   = brb_pkg::t_status'(m_axis_tdata[9:8]);
            got.lvl  = m_axis_tdata[18:10];
            got.last = m_axis_tlast;
            if (due_results.size() == 0) begin
                note_mismatch("result with nothing pending", '0, got);
            end else begin
                want = due_results.pop_front();
                if (got.data !== want.data || got.st !== want.st ||
                    got.lvl !== want.lvl || got.last !== want.last) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Receiver stalls in bursts, with quiet stretches and none at the end.
    initial begin
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
            if (!calm && !rx_quiet && $urandom_range(0, 11) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Present one request and hold it until the transfer; returns at a falling edge.
    task automatic send_req(input t_ring_req it, input logic fixed, input t_ring_result res);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        ring_apply(it);
        // A fixed expectation stands in for the computed single result.
        if (fixed) due_results[due_results.size() - 1] = res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, it.cnt, it.din};
        s_axis_tuser  <= {it.first, it.req};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop sending until every pending result has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (due_results.size() != 0);
    endtask

    // One random burst: a write block, or a single read, control or noise request.
    task automatic make_burst(output t_ring_req q [$]);
        int            cap;
        int            lv;
        int            k;
        int            len;
        int            extra;
        int            cnt;
        brb_pkg::t_req kind;
        bit            fb;
        cap = ring_cap();
        lv  = ring_fill();
        k   = $urandom_range(0, 99);
        q.delete();
        if (k < 40) begin
            // Block length: sometimes huge, sometimes at or just past the free space.
            k = $urandom_range(0, 9);
            if (k == 0) len = $urandom_range(0, 256);
            else if (k < 3) len = cap - lv + $urandom_range(0, 2);
            else len = $urandom_range(1, (cap < 12) ? cap : 12);
            if (len > 256) len = 256;
            q.push_back('{brb_pkg::REQ_WRITE, 8'($urandom), 9'(len), 1'b1});
            extra = (len > 0) ? len - 1 : 0;
            if ($urandom_range(0, 7) == 0) extra++;
            else if (extra > 0 && $urandom_range(0, 7) == 0) extra = $urandom_range(0, extra - 1);
            repeat (extra) q.push_back('{brb_pkg::REQ_WRITE, 8'($urandom),
                                          9'($urandom_range(0, 256)), 1'b0});
            return;
        end
        cnt  = $urandom_range(0, 256);
        fb   = 1'($urandom);
        kind = brb_pkg::REQ_LEVEL;
        if (k < 55) begin
            kind = brb_pkg::REQ_GETBLK;
            if ($urandom_range(0, 3) != 0)
                cnt = $urandom_range(1, (lv < 1) ? 1 :
                                        ((lv > brb_pkg::MAX_BLOCK) ? brb_pkg::MAX_BLOCK : lv));
        end else if (k < 70) begin
            kind = ($urandom_range(0, 2) == 0) ? brb_pkg::REQ_PEEK : brb_pkg::REQ_GET;
        end else if (k < 82) begin
            kind = brb_pkg::REQ_REWIND;
            if ($urandom_range(0, 4) != 0) cnt = $urandom_range(1, cap);
        end else if (k < 88) begin
            kind = brb_pkg::REQ_LEVEL;
        end else if (k < 91) begin
            kind = brb_pkg::REQ_CLEAR;
        end else if (k < 94) begin
            kind = brb_pkg::REQ_NOP;
        end else begin
            // Stray byte outside any block.
            kind = brb_pkg::REQ_WRITE;
            fb   = 1'b0;
        end
        q.push_back('{kind, 8'($urandom), 9'(cnt), fb});
    endtask

    // Set the capacity on an idle block, then run random traffic with it.
    task automatic run_phase(input int cap_val, input bit keep_ptrs, input int n_items);
        t_ring_req burst [$];
        int        sent;
        sent = 0;
        drain();
        repeat (8) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 9'(cap_val);
        shadow_cap   = cap_val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (!keep_ptrs) send_req('{brb_pkg::REQ_CLEAR, 8'h00, 9'd0, 1'b0}, 1'b0, '0);
        while (sent < n_items) begin
            make_burst(burst);
            // A long block is cut off once the phase has sent its share.
            while (burst.size() != 0 && sent < n_items) begin
                if (sent == n_items / 2) drain();
                send_req(burst.pop_front(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed rows, then random phases over several capacities.
    initial begin
        ring_clear();
        shadow_cap = 256;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_tab[i]) send_req(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].res);
        run_phase(256, 1'b1, 70);
        // Shrink without a clear so that the pointers are left past the capacity.
        run_phase(5, 1'b1, 40);
        run_phase(1, 1'b0, 50);
        run_phase(16, 1'b0, 90);
        run_phase(200, 1'b0, 60);
        calm = 1'b1;
        run_phase(256, 1'b0, 90);
        drain();
        repeat (20) @(negedge i_clk);
        if (mismatch_cnt == 0 && due_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/brb_pkg.sv
hdl/brb_ctrl.sv
hdl/brb_datapath.sv
hdl/byte_ring_buffer_rewind.sv
test/tb_top.sv
